FILE: hdl/fifo_handoff_mutex_assert.svh
// fifo_handoff_mutex_assert.svh: assertion macros for the mutex checker.
// Depends on nothing; the file that includes it supplies clk and arst_n.
`ifndef FIFO_HANDOFF_MUTEX_ASSERT_SVH
`define FIFO_HANDOFF_MUTEX_ASSERT_SVH

// Clocked check, idle while reset is asserted.
`define FHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FHM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/fhm_pkg.sv
// fhm_pkg: shared constants, codes and controller/datapath types for the
// FIFO handoff mutex. No dependencies.
package fhm_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int TASK_ID_WIDTH = 8;
	localparam int PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

	// operation codes
	localparam logic [1:0] OP_LOCK    = 2'd0;
	localparam logic [1:0] OP_UNLOCK  = 2'd1;
	localparam logic [1:0] OP_TRYLOCK = 2'd2;

	// result status codes
	localparam logic [2:0] ST_GRANTED   = 3'd0;
	localparam logic [2:0] ST_QUEUED    = 3'd1;
	localparam logic [2:0] ST_BUSY      = 3'd2;
	localparam logic [2:0] ST_RECURSIVE = 3'd3;
	localparam logic [2:0] ST_NOT_OWNER = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_GRANT,
		ACT_ENQUEUE,
		ACT_HANDOFF,
		ACT_RELEASE
	} act_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       exec;
		act_t       act;
		logic [2:0] status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       owner_present;
		logic       owner_match;
		logic       q_empty;
		logic       q_full;
	} sts_t;

endpackage

FILE: hdl/fhm_datapath.sv
// fhm_datapath: request capture, owner registers, waiter FIFO memory and
// result registers. Depends on fhm_pkg; driven by fhm_ctrl commands.
module fhm_datapath import fhm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] operation,
	input  logic [7:0] task_id,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic [2:0] status,
	output logic       wake_valid,
	output logic [7:0] wake_task,
	output logic       locked,
	output logic [7:0] owner_task,
	output logic [4:0] waiter_count
);

	logic [1:0]               op_q;
	logic [TASK_ID_WIDTH-1:0] id_q;
	logic [TASK_ID_WIDTH-1:0] rd_q;
	logic [TASK_ID_WIDTH-1:0] queue_mem [QUEUE_DEPTH];
	logic                     owner_present_q;
	logic [TASK_ID_WIDTH-1:0] owner_q;
	logic [PTR_W-1:0]         head_q;
	logic [PTR_W-1:0]         tail_q;
	logic [CNT_W-1:0]         count_q;
	logic [2:0]               status_q;
	logic                     wake_valid_q;
	logic [TASK_ID_WIDTH-1:0] wake_task_q;
	logic [PTR_W-1:0]         head_nxt;
	logic [PTR_W-1:0]         tail_nxt;

	// request beat capture, full task id
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
			id_q <= task_id[TASK_ID_WIDTH-1:0];
		end
	end

	// waiter FIFO: head read registered every cycle, push at tail
	always_ff @(posedge clk) begin
		rd_q <= queue_mem[head_q];
		if (cmd.exec && cmd.act == ACT_ENQUEUE) begin
			queue_mem[tail_q] <= id_q;
		end
	end

	// pointer wrap
	assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// owner and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_present_q <= 1'b0;
			owner_q         <= '0;
			head_q          <= '0;
			tail_q          <= '0;
			count_q         <= '0;
		end else if (cmd.exec) begin
			case (cmd.act)
				ACT_GRANT: begin
					owner_present_q <= 1'b1;
					owner_q         <= id_q;
				end
				ACT_ENQUEUE: begin
					tail_q  <= tail_nxt;
					count_q <= count_q + 1'b1;
				end
				ACT_HANDOFF: begin
					owner_q <= rd_q;
					head_q  <= head_nxt;
					count_q <= count_q - 1'b1;
				end
				ACT_RELEASE: begin
					owner_present_q <= 1'b0;
					owner_q         <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= cmd.status;
			wake_valid_q <= (cmd.act == ACT_HANDOFF);
			wake_task_q  <= (cmd.act == ACT_HANDOFF) ? rd_q : '0;
		end
	end

	// flags for the controller
	always_comb begin
		sts.op            = op_q;
		sts.owner_present = owner_present_q;
		sts.owner_match   = owner_present_q && (owner_q == id_q);
		sts.q_empty       = (count_q == '0);
		sts.q_full        = (count_q == CNT_W'(QUEUE_DEPTH));
	end

	assign status       = status_q;
	assign wake_valid   = wake_valid_q;
	assign wake_task    = 8'(wake_task_q);
	assign locked       = owner_present_q;
	assign owner_task   = 8'(owner_q);
	assign waiter_count = 5'(count_q);

endmodule

FILE: hdl/fhm_ctrl.sv
// fhm_ctrl: request sequencer and decision logic for the mutex.
// Depends on fhm_pkg; commands fhm_datapath.
module fhm_ctrl import fhm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	act_t       act;
	logic [2:0] code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_EXEC;
			S_EXEC: state_nxt = S_OUT;
			S_OUT:  if (out_ready) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// decide what the captured request does
	always_comb begin
		act  = ACT_NONE;
		code = ST_BUSY;
		case (sts.op)
			OP_LOCK: begin
				if (sts.owner_match) begin
					code = ST_RECURSIVE;
				end else if (!sts.owner_present) begin
					act  = ACT_GRANT;
					code = ST_GRANTED;
				end else if (sts.q_full) begin
					code = ST_FULL;
				end else begin
					act  = ACT_ENQUEUE;
					code = ST_QUEUED;
				end
			end
			OP_UNLOCK: begin
				if (!sts.owner_match) begin
					code = ST_NOT_OWNER;
				end else if (!sts.q_empty) begin
					act  = ACT_HANDOFF;
					code = ST_GRANTED;
				end else begin
					act  = ACT_RELEASE;
					code = ST_GRANTED;
				end
			end
			OP_TRYLOCK: begin
				if (!sts.owner_present) begin
					act  = ACT_GRANT;
					code = ST_GRANTED;
				end
			end
			default: begin
			end
		endcase
	end

	// outputs per state
	always_comb begin
		in_ready    = (state_q == S_IDLE);
		out_valid   = (state_q == S_OUT);
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.act     = act;
		cmd.status  = code;
	end

endmodule

FILE: hdl/fifo_handoff_mutex.sv
// fifo_handoff_mutex: top level of the FIFO-queued hardware mutex.
// Depends on fhm_pkg, fhm_ctrl and fhm_datapath.
//
//   channel  handshake            payload
//   -------  -------------------  --------------------------------------------
//   in       in_valid / in_ready  operation, task_id
//   out      out_valid/ out_ready status, wake_valid, wake_task, locked,
//                                 owner_task, waiter_count
//
// A request steps through capture, execute and present, in that order. The
// execute step waits on the registered read of the waiter FIFO head. One
// request is in flight at a time; in_ready is low from capture until the
// result beat is taken, so a stalled out holds off in.
// Reset is asynchronous; the FIFO memory is not cleared, no clearing pass.
module fifo_handoff_mutex import fhm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] task_id,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       wake_valid,
	output logic [7:0] wake_task,
	output logic       locked,
	output logic [7:0] owner_task,
	output logic [4:0] waiter_count
);

	cmd_t cmd;
	sts_t sts;

	fhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fhm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.task_id      (task_id),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.wake_valid   (wake_valid),
		.wake_task    (wake_task),
		.locked       (locked),
		.owner_task   (owner_task),
		.waiter_count (waiter_count)
	);

endmodule

FILE: hdl/fhm_checker.sv
// fhm_checker: port-level checks on the mutex result channel, bound to the
// top level. Depends on fhm_pkg and fifo_handoff_mutex_assert.svh.
`include "fifo_handoff_mutex_assert.svh"

module fhm_checker import fhm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic       wake_valid,
	input logic [7:0] wake_task,
	input logic       locked,
	input logic [7:0] owner_task,
	input logic [4:0] waiter_count
);

	// a stalled result beat holds its status
	`FHM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status), "result beat changed while stalled")

	// a woken task is the new owner of a held mutex
	`FHM_ASSERT(a_wake_owner, out_valid && wake_valid |-> locked && owner_task == wake_task && status == ST_GRANTED, "wake does not match owner")

	// waiters only exist while the mutex is held, and never exceed the depth
	`FHM_ASSERT(a_waiters_held, out_valid && waiter_count != 5'd0 |-> locked && waiter_count <= 5'(QUEUE_DEPTH), "waiters without owner or too many waiters")

	// a free mutex reports no owner and no wake
	`FHM_ASSERT(a_free_clean, out_valid && !locked |-> owner_task == 8'd0 && !wake_valid, "free mutex reports owner or wake")

	// nothing is presented while in reset
	`FHM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind fifo_handoff_mutex fhm_checker u_fhm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.wake_valid   (wake_valid),
	.wake_task    (wake_task),
	.locked       (locked),
	.owner_task   (owner_task),
	.waiter_count (waiter_count)
);
